>>> design/ehci_pkg.sv
// Package with shared types and constants of the ELF hash chain insert block.
package ehci_pkg;

  localparam int BUCKETS = 256;
  localparam int SYMBOLS = 1024;
  localparam int BW = $clog2(BUCKETS);
  localparam int SW = $clog2(SYMBOLS);

  localparam logic [27:0] HASH_MASK = 28'hfffffff;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_READ_DONE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_HEAD_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_READ,
    S_READ_WAIT,
    S_OUT
  } state_t;

  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;
  localparam logic [0:0] REG_SYMBOL_COUNT = 1'b1;

  // Fold one name byte into the 28-bit ELF hash.
  function automatic logic [27:0] fold_byte(input logic [27:0] h, input logic [7:0] c);
    logic [31:0] x;
    begin
      x = {h, 4'h0} + {24'h0, c};
      x = x ^ {24'h0, x[31:28], 4'h0};
      return x[27:0];
    end
  endfunction

endpackage

>>> design/elf_hash_chain_insert.sv
// Hashes streamed symbol names and appends indexes to the bucket chains
// of an ELF SysV hash table held in two on-chip memories. The block takes
// one transfer at a time and holds off its input until the result of that
// transfer has been taken. A non-last name byte gives no result, so the
// next byte can follow in the very next cycle. A last byte passes through
// the bit-serial modulo and then reads the bucket head (S_HEAD, S_HEAD_WAIT)
// before its result is offered; each link visited on the chain walk adds
// a registered chain memory read (S_WALK, S_WALK_WAIT). A bad index is
// reported right after the modulo, and an empty name in the cycle after
// acceptance. A read of a table word passes through S_READ and S_READ_WAIT
// before its result is offered. The memories are cleared after reset by a
// pass over all 1024 link addresses, during which no item is taken.
module elf_hash_chain_insert (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  name_byte,
  input  logic        last_byte,
  input  logic [9:0]  symbol_index,
  input  logic [10:0] read_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  bucket,
  output logic [9:0]  predecessor,
  output logic [10:0] read_data
);
  import ehci_pkg::*;

  logic [SW-1:0] heads_mem [BUCKETS];
  logic [SW-1:0] links_mem [SYMBOLS];

  logic [8:0]  bucket_count;
  logic [10:0] symbol_count;
  logic [BW:0] nb;
  logic [SW:0] ns;

  state_t state, state_next;
  logic [27:0] running_hash;
  logic        name_started;
  logic        clearing;
  logic [SW-1:0] clear_addr;

  logic [SW-1:0] sym;
  logic [BW-1:0] bkt;
  logic [SW-1:0] pred;
  logic [SW:0]   steps;
  logic [SW-1:0] head_rd, link_rd;
  logic [SW-1:0] link_addr;
  logic          is_chain_rd;
  logic          is_head_rd;
  logic [2:0]    res_status;
  logic [SW:0]   res_data;
  logic          accept;
  logic          mod_done;
  logic [BW-1:0] mod_rem;
  logic [10:0]   addr_b, addr_c;

  // Effective register values, limited to their legal ranges.
  always_comb begin
    if (bucket_count == 9'd0) nb = (BW+1)'(1);
    else if (bucket_count > 9'(BUCKETS)) nb = (BW+1)'(BUCKETS);
    else nb = bucket_count[BW:0];
    if (symbol_count == 11'd0) ns = (SW+1)'(1);
    else if (symbol_count > 11'(SYMBOLS)) ns = (SW+1)'(SYMBOLS);
    else ns = symbol_count[SW:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 9'd1;
      symbol_count <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BUCKET_COUNT: bucket_count <= cfg_data[8:0];
        REG_SYMBOL_COUNT: symbol_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE) && !clearing;
  assign accept   = in_valid && in_ready;

  ehci_mod u_mod (
    .clk(clk), .rst(rst),
    .start(accept && !operation && last_byte && (name_started || name_byte != 8'd0)),
    .dividend((name_byte != 8'd0) ? fold_byte(running_hash, name_byte) : running_hash),
    .divisor(nb), .done(mod_done), .remainder(mod_rem)
  );

  assign addr_b = read_address - 11'd2;
  assign addr_c = addr_b - 11'(nb);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        if (operation) state_next = S_READ;
        else if (last_byte) begin
          if (!name_started && name_byte == 8'd0) state_next = S_OUT;
          else state_next = S_MOD;
        end
      end
      S_MOD:       if (mod_done) state_next = (sym == '0 || {1'b0, sym} >= ns) ? S_OUT : S_HEAD;
      S_HEAD:      state_next = S_HEAD_WAIT;
      S_HEAD_WAIT: state_next = S_OUT;
      S_WALK:      state_next = S_WALK_WAIT;
      S_WALK_WAIT: state_next = S_OUT;
      S_READ:      state_next = S_READ_WAIT;
      S_READ_WAIT: state_next = S_OUT;
      S_OUT:       if (out_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
    if (state == S_HEAD_WAIT && head_rd != '0) begin
      if ({1'b0, head_rd} >= ns || steps >= ns) state_next = S_OUT;
      else state_next = S_WALK;
    end
    if (state == S_WALK_WAIT && link_rd != '0) begin
      if ({1'b0, link_rd} >= ns || steps >= ns) state_next = S_OUT;
      else state_next = S_WALK;
    end
  end

  // Datapath, memories and results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      running_hash <= '0;
      name_started <= 1'b0;
      clearing     <= 1'b1;
      clear_addr   <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clear_addr <= clear_addr + SW'(1);
        if (clear_addr == SW'(SYMBOLS - 1)) clearing <= 1'b0;
      end
      if (accept && !operation) begin
        if (last_byte) begin
          running_hash <= '0;
          name_started <= 1'b0;
        end else if (name_byte != 8'd0) begin
          running_hash <= fold_byte(running_hash, name_byte);
          name_started <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    head_rd <= heads_mem[bkt];
    link_rd <= links_mem[link_addr];
    if (clearing) begin
      links_mem[clear_addr] <= '0;
      if (clear_addr < SW'(BUCKETS)) heads_mem[clear_addr[BW-1:0]] <= '0;
    end
    unique case (state)
      S_IDLE: if (accept) begin
        sym   <= symbol_index;
        pred  <= '0;
        steps <= '0;
        bkt   <= '0;
        res_data <= '0;
        res_status <= ST_EMPTY;
        is_chain_rd <= 1'b0;
        is_head_rd <= 1'b0;
        if (operation) begin
          res_status <= ST_READ_DONE;
          if (read_address == 11'd0) res_data <= (SW+1)'(nb);
          else if (read_address == 11'd1) res_data <= ns;
          else if (addr_b < 11'(nb)) begin
            bkt <= addr_b[BW-1:0];
            is_head_rd <= 1'b1;
          end else if (addr_c < 11'(ns)) begin
            link_addr <= addr_c[SW-1:0];
            is_chain_rd <= 1'b1;
          end
        end
      end
      S_MOD: if (mod_done) begin
        bkt <= mod_rem;
        res_status <= ST_BAD_INDEX;
      end
      S_HEAD_WAIT: begin
        if (head_rd == '0) begin
          heads_mem[bkt] <= sym;
          res_status <= ST_INSERTED;
        end else if ({1'b0, head_rd} >= ns || steps >= ns) res_status <= ST_TOO_LONG;
        else begin
          pred <= head_rd;
          link_addr <= head_rd;
          steps <= steps + (SW+1)'(1);
        end
      end
      S_WALK_WAIT: begin
        if (link_rd == '0) begin
          links_mem[pred] <= sym;
          res_status <= ST_INSERTED;
        end else if ({1'b0, link_rd} >= ns || steps >= ns) res_status <= ST_TOO_LONG;
        else begin
          pred <= link_rd;
          link_addr <= link_rd;
          steps <= steps + (SW+1)'(1);
        end
      end
      S_READ_WAIT: begin
        if (is_chain_rd) res_data <= {1'b0, link_rd};
        else if (is_head_rd) res_data <= {1'b0, head_rd};
      end
      default: ;
    endcase
  end

  // Output fields.
  assign out_valid   = (state == S_OUT);
  assign status      = res_status;
  assign bucket      = (res_status == ST_READ_DONE || res_status == ST_EMPTY) ? 8'd0 : 8'(bkt);
  assign predecessor = (res_status == ST_INSERTED) ? pred : 10'd0;
  assign read_data   = (res_status == ST_READ_DONE) ? 11'(res_data) : 11'd0;

  // No item is taken while the memories are cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready) else $error("item accepted during clear");
  // A result is held until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)) else $error("result dropped");
  // The walk never exceeds the symbol count.
  a_steps: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_WALK_WAIT) |-> steps <= ns) else $error("walk overran");
endmodule

>>> design/ehci_mod.sv
// Iterative remainder unit: hash modulo bucket count, one bit per cycle.
module ehci_mod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [27:0]          dividend,
  input  logic [ehci_pkg::BW:0] divisor,
  output logic                 done,
  output logic [ehci_pkg::BW-1:0] remainder
);
  import ehci_pkg::*;

  logic [27:0] shreg;
  logic [BW:0] rem;
  logic [4:0]  count;
  logic        busy;
  logic [BW+1:0] trial;

  // Shift one dividend bit into the partial remainder.
  assign trial = {rem, shreg[27]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd0;
        shreg <= dividend;
        rem   <= '0;
      end else if (busy) begin
        shreg <= {shreg[26:0], 1'b0};
        if (trial >= {1'b0, divisor}) rem <= (BW+1)'(trial - {1'b0, divisor});
        else rem <= trial[BW:0];
        count <= count + 5'd1;
        if (count == 5'd27) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[BW-1:0];
endmodule

>>> sim/elf_hash_chain_insert_tb.sv
// Self-checking testbench for the ELF hash chain insert block.
module elf_hash_chain_insert_tb;
  import ehci_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One name byte or table read, as offered to the block.
  typedef struct {
    logic        operation;
    logic [7:0]  name_byte;
    logic        last_byte;
    logic [9:0]  symbol_index;
    logic [10:0] read_address;
  } req_t;

  // One table update or read reply, as returned by the block.
  typedef struct {
    status_t     status;
    logic [7:0]  bucket;
    logic [9:0]  predecessor;
    logic [10:0] read_data;
  } reply_t;

  // A row of the directed table; has_fixed marks an expectation typed in.
  typedef struct {
    req_t   req;
    bit     has_fixed;
    reply_t fixed;
  } row_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int   STALL_LIMIT = 20000;
  localparam int   DRAIN_CYCLES = 3000;

  logic        clk, rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_valid, in_ready;
  logic        operation, last_byte;
  logic [7:0]  name_byte;
  logic [9:0]  symbol_index;
  logic [10:0] read_address;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [7:0]  bucket;
  logic [9:0]  predecessor;
  logic [10:0] read_data;

  elf_hash_chain_insert dut (.*);

  // Predictor copy of the hash table.
  logic [9:0]  heads_model [BUCKETS];
  logic [9:0]  links_model [SYMBOLS];
  logic [27:0] hash_acc;
  bit          name_open;
  logic [8:0]  nbucket_reg;
  logic [10:0] nsym_reg;

  reply_t pending_replies[$];
  int     errors;
  int     idle_cycles;
  int     inserts_seen, reads_seen, rejects_seen;
  bit     hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_buckets();
    if (nbucket_reg == 0) return 1;
    if (nbucket_reg > BUCKETS) return BUCKETS;
    return nbucket_reg;
  endfunction

  function automatic int unsigned eff_symbols();
    if (nsym_reg == 0) return 1;
    if (nsym_reg > SYMBOLS) return SYMBOLS;
    return nsym_reg;
  endfunction

  // Model the table update for one accepted transfer; returns 1 with a reply.
  function automatic bit predict_table(input req_t r, output reply_t rep);
    int unsigned nb, ns, b, pos, pred, steps, addr;
    logic [35:0] x;
    bit          fail;
    nb = eff_buckets();
    ns = eff_symbols();
    rep = '{ST_INSERTED, 8'd0, 10'd0, 11'd0};
    if (r.operation == OP_READ) begin
      addr = r.read_address;
      rep.status = ST_READ_DONE;
      if (addr == 0) rep.read_data = 11'(nb);
      else if (addr == 1) rep.read_data = 11'(ns);
      else if (addr - 2 < nb) rep.read_data = {1'b0, heads_model[addr - 2]};
      else if (addr - 2 - nb < ns) rep.read_data = {1'b0, links_model[addr - 2 - nb]};
      return 1;
    end
    if (r.name_byte != 0) begin
      x = {4'h0, hash_acc, 4'h0} + r.name_byte;
      if (x[31:28] != 0) x = x ^ (x[31:28] << 4);
      hash_acc = x[27:0];
      name_open = 1;
    end
    if (!r.last_byte) return 0;
    b = hash_acc % nb;
    hash_acc = '0;
    if (!name_open) begin
      rep.status = ST_EMPTY;
      return 1;
    end
    name_open = 0;
    rep.bucket = 8'(b);
    if (r.symbol_index == 0 || r.symbol_index >= ns) begin
      rep.status = ST_BAD_INDEX;
      return 1;
    end
    pos = heads_model[b];
    pred = 0;
    steps = 0;
    fail = 0;
    while (pos != 0) begin
      if (pos >= ns || steps >= ns) begin
        fail = 1;
        break;
      end
      pred = pos;
      pos = links_model[pos];
      steps++;
    end
    if (fail) begin
      rep.status = ST_TOO_LONG;
      return 1;
    end
    if (pred == 0) heads_model[b] = r.symbol_index;
    else links_model[pred] = r.symbol_index;
    rep.predecessor = 10'(pred);
    return 1;
  endfunction

  // Idle-time register write, mirrored into the predictor.
  task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BUCKET_COUNT) nbucket_reg = val[8:0];
    else nsym_reg = val;
  endtask

  // Offer one transfer after a random gap and wait for acceptance.
  // Valid stays high into the next transfer when no gap is drawn.
  task automatic send_req(input req_t r, input bit has_fixed, input reply_t fixed);
    reply_t rep;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= r.operation;
    name_byte <= r.name_byte;
    last_byte <= r.last_byte;
    symbol_index <= r.symbol_index;
    read_address <= r.read_address;
    do @(posedge clk); while (!in_ready);
    if (predict_table(r, rep)) pending_replies.push_back(has_fixed ? fixed : rep);
    @(negedge clk);
  endtask

  // Wait until every reply is in, plus room for a name in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  function automatic req_t byte_req(input logic [7:0] c, input logic last,
                                    input logic [9:0] sym);
    byte_req = '{OP_BYTE, c, last, sym, 11'($urandom_range(0, 2047))};
  endfunction

  function automatic req_t read_req(input logic [10:0] a);
    read_req = '{OP_READ, 8'($urandom), 1'($urandom), 10'($urandom), a};
  endfunction

  // Send a random name of 1..6 bytes that ends with the given index.
  task automatic send_name(input logic [9:0] sym);
    int len;
    reply_t none;
    none = '{ST_INSERTED, 8'd0, 10'd0, 11'd0};
    len = $urandom_range(1, 6);
    for (int k = 0; k < len; k++)
      send_req(byte_req(($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom),
                        k == len - 1, sym), 0, none);
  endtask

  // Receiver side: random back-pressure and in-order comparison.
  initial begin
    reply_t want;
    int wait_n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (pending_replies.size() == 0) begin
        $error("reply with no expectation: status %0d", status);
        errors++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
        if (bucket !== want.bucket) begin
          $error("bucket: expected %0d, got %0d", want.bucket, bucket);
          errors++;
        end
        if (predecessor !== want.predecessor) begin
          $error("predecessor: expected %0d, got %0d", want.predecessor, predecessor);
          errors++;
        end
        if (read_data !== want.read_data) begin
          $error("read_data: expected %0d, got %0d", want.read_data, read_data);
          errors++;
        end
        case (want.status)
          ST_INSERTED:  inserts_seen++;
          ST_READ_DONE: reads_seen++;
          default:      rejects_seen++;
        endcase
      end
    end
  end

  // Watchdog on cycles without any transfer; allows for the clearing pass.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Main stimulus: directed table, then random phases over several settings.
  initial begin
    row_t   dir_rows[$];
    reply_t none;
    int     total;
    none = '{ST_INSERTED, 8'd0, 10'd0, 11'd0};
    errors = 0;
    hold_off = 0;
    inserts_seen = 0;
    reads_seen = 0;
    rejects_seen = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BUCKET_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_BYTE;
    name_byte = '0;
    last_byte = 1'b0;
    symbol_index = '0;
    read_address = '0;
    foreach (heads_model[i]) heads_model[i] = '0;
    foreach (links_model[i]) links_model[i] = '0;
    hash_acc = '0;
    name_open = 0;
    nbucket_reg = 9'd1;
    nsym_reg = 11'd1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset header, empty names, bad indexes, then extreme inserts.
    dir_rows.push_back('{read_req(11'd0), 1, '{ST_READ_DONE, 8'd0, 10'd0, 11'd1}});
    dir_rows.push_back('{read_req(11'd1), 1, '{ST_READ_DONE, 8'd0, 10'd0, 11'd1}});
    dir_rows.push_back('{read_req(11'd2047), 1, '{ST_READ_DONE, 8'd0, 10'd0, 11'd0}});
    dir_rows.push_back('{byte_req(8'd0, 1, 10'd5), 1, '{ST_EMPTY, 8'd0, 10'd0, 11'd0}});
    dir_rows.push_back('{byte_req(8'd0, 0, 10'd0), 0, none});
    dir_rows.push_back('{byte_req(8'd0, 1, 10'd1023), 1, '{ST_EMPTY, 8'd0, 10'd0, 11'd0}});
    dir_rows.push_back('{byte_req(8'd255, 1, 10'd1), 1,
                         '{ST_BAD_INDEX, 8'd0, 10'd0, 11'd0}});
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed);
    drain();
    dir_rows.delete();
    write_reg(REG_BUCKET_COUNT, 11'd256);
    write_reg(REG_SYMBOL_COUNT, 11'd1024);
    dir_rows.push_back('{read_req(11'd0), 1, '{ST_READ_DONE, 8'd0, 10'd0, 11'd256}});
    dir_rows.push_back('{read_req(11'd1), 1, '{ST_READ_DONE, 8'd0, 10'd0, 11'd1024}});
    dir_rows.push_back('{byte_req(8'd65, 1, 10'd0), 1,
                         '{ST_BAD_INDEX, 8'd65, 10'd0, 11'd0}});
    dir_rows.push_back('{byte_req(8'd65, 1, 10'd1023), 1, '{ST_INSERTED, 8'd65, 10'd0, 11'd0}});
    dir_rows.push_back('{byte_req(8'd65, 1, 10'd1), 1,
                         '{ST_INSERTED, 8'd65, 10'd1023, 11'd0}});
    dir_rows.push_back('{byte_req(8'd65, 1, 10'd1023), 0, none});
    for (int k = 0; k < 8; k++) dir_rows.push_back('{byte_req(8'hff, 0, 10'd0), 0, none});
    dir_rows.push_back('{byte_req(8'h80, 1, 10'd512), 0, none});
    dir_rows.push_back('{read_req(11'd67), 0, none});
    dir_rows.push_back('{read_req(11'd258 + 11'd1023), 0, none});
    dir_rows.push_back('{read_req(11'd1282), 0, none});
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed);
    drain();

    // Random phases: each setting mixes names, noise and table reads.
    total = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(REG_BUCKET_COUNT, 11'd0); write_reg(REG_SYMBOL_COUNT, 11'd0); end
        1: begin write_reg(REG_BUCKET_COUNT, 11'd1); write_reg(REG_SYMBOL_COUNT, 11'd8); end
        2: begin write_reg(REG_BUCKET_COUNT, 11'd511); write_reg(REG_SYMBOL_COUNT, 11'd2047); end
        3: begin write_reg(REG_BUCKET_COUNT, 11'd3); write_reg(REG_SYMBOL_COUNT, 11'd40); end
        4: begin write_reg(REG_BUCKET_COUNT, 11'd17); write_reg(REG_SYMBOL_COUNT, 11'd16); end
        default: begin
          write_reg(REG_BUCKET_COUNT, 11'($urandom_range(1, 256)));
          write_reg(REG_SYMBOL_COUNT, 11'($urandom_range(2, 64)));
        end
      endcase
      if (phase == 3) hold_off = 1;
      for (int n = 0; n < 100; n++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            send_req(read_req(11'($urandom_range(0, eff_buckets() + eff_symbols() + 3))),
                     0, none);
            total++;
          end
          2: begin
            send_req(byte_req(8'($urandom), 1'($urandom), 10'($urandom)), 0, none);
            total++;
          end
          default: begin
            send_name((eff_symbols() > 1 && $urandom_range(0, 7) != 0)
                      ? 10'($urandom_range(1, eff_symbols() - 1)) : 10'($urandom));
            total += 4;
          end
        endcase
      end
      // Finish any open name so the next setting starts clean.
      send_req(byte_req(8'($urandom_range(1, 255)), 1, 10'd0), 0, none);
      drain();
    end

    repeat (DRAIN_CYCLES / 10) @(negedge clk);
    $display("Covered about %0d random transfers: %0d inserts, %0d reads, %0d rejects.",
             total, inserts_seen, reads_seen, rejects_seen);
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
